// ===== rtl/seq_retransmit_ring_with_backoff_core_macros.svh =====
// assertion macros used by the checker file
`ifndef SEQ_RETRANSMIT_RING_WITH_BACKOFF_CORE_MACROS_SVH
`define SEQ_RETRANSMIT_RING_WITH_BACKOFF_CORE_MACROS_SVH

// clocked assertion that is off while reset is high
`define SRB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define SRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/seqrt_pkg.sv =====
// types and constants of the retransmission ring
`default_nettype none
package seqrt_pkg;
   localparam int SEQ_W = 48;
   localparam int MS_W = 20;
   localparam int HDL_W = 16;

   localparam logic [1:0] KIND_STORE  = 2'd0;
   localparam logic [1:0] KIND_ACK    = 2'd1;
   localparam logic [1:0] KIND_RESEND = 2'd2;
   localparam logic [1:0] KIND_TICK   = 2'd3;

   localparam logic [1:0] CSR_ACK_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_EMG_MIN     = 2'd1;
   localparam logic [1:0] CSR_EMG_MAX     = 2'd2;

   localparam logic [MS_W-1:0] ACK_TIMEOUT_RST = 20'd10000;
   localparam logic [MS_W-1:0] EMG_MIN_RST     = 20'd100;
   localparam logic [MS_W-1:0] EMG_MAX_RST     = 20'd1000;

   typedef struct packed {
      logic [1:0]       kind;
      logic [SEQ_W-1:0] seq;
      logic [HDL_W-1:0] msg_handle;
      logic [SEQ_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic            do_send;
      logic [HDL_W-1:0] send_handle;
      logic            emergency;
      logic            rejected;
      logic            wait_none;
      logic [MS_W-1:0] wait_ms;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [HDL_W-1:0] handle;
      logic [SEQ_W-1:0] stamp;
   } slot_type;
endpackage
`default_nettype wire

// ===== rtl/seqrt_slot_ram.sv =====
// slot store: valid bit, handle and timestamp per ring slot
`default_nettype none
module seqrt_slot_ram
   import seqrt_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      we_all,
   input  wire logic                      we_valid,
   input  wire logic [$clog2(SLOTS)-1:0]  waddr,
   input  wire slot_type                  wdata,
   input  wire logic [$clog2(SLOTS)-1:0]  raddr,
   output slot_type                       rdata
);
   logic             valid_mem  [SLOTS];
   logic [HDL_W-1:0] handle_mem [SLOTS];
   logic [SEQ_W-1:0] stamp_mem  [SLOTS];
   slot_type         rdata_ff;

   // valid bit is written alone by clears, all fields by a store
   always_ff @(posedge clock) begin
      if (we_all || we_valid) begin
         valid_mem[waddr] <= wdata.valid;
      end
      if (we_all) begin
         handle_mem[waddr] <= wdata.handle;
         stamp_mem[waddr]  <= wdata.stamp;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff.valid  <= valid_mem[raddr];
      rdata_ff.handle <= handle_mem[raddr];
      rdata_ff.stamp  <= stamp_mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== rtl/seq_retransmit_ring_with_backoff_core.sv =====
// Sender-side retransmission ring with emergency retransmit backoff.
// Requests arrive on req_valid/req_ready with req_data; every request gives
// exactly one result on rsp_valid/rsp_ready with rsp_data. kind selects
// store, ack, resend lookup or time tick. Registers are written through
// csr_we/csr_index/csr_wdata; the user writes them only while the block
// is idle, and the block itself does not enforce this. One request is
// worked on at a time by a small sequencer around the slot memory. A
// tick with an empty ring or no peer answers wait_none. A stale store is
// rejected; other stores step once per skipped sequence and once each
// time a full ring drops its oldest entry, and a store with a gap of SLOTS
// or more sweeps the whole memory. An ack steps once per freed entry.
// req_ready comes back together with rsp_valid when the result is loaded.
// A new request is taken while a finished result still waits in the
// output register, and its own result waits until that register frees
// up when the receiver stalls. After reset the block clears every valid
// bit, one slot per cycle, with req_ready low until the sweep ends; csr
// writes are taken meanwhile.
`default_nettype none
module seq_retransmit_ring_with_backoff_core
   import seqrt_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [MS_W-1:0]  csr_wdata
);
   localparam int IW = $clog2(SLOTS);
   localparam int CW = IW + 1;
   localparam logic [IW-1:0]    LAST     = IW'(SLOTS - 1);
   localparam logic [CW-1:0]    SLOTS_C  = CW'(SLOTS);
   localparam logic [SEQ_W-1:0] SLOTS_S  = SEQ_W'(SLOTS);

   localparam logic [4:0] ST_CLEAR   = 5'd0;
   localparam logic [4:0] ST_IDLE    = 5'd1;
   localparam logic [4:0] ST_DEC     = 5'd2;
   localparam logic [4:0] ST_GAPCHK  = 5'd3;
   localparam logic [4:0] ST_STEP    = 5'd4;
   localparam logic [4:0] ST_FIX     = 5'd5;
   localparam logic [4:0] ST_WRITE   = 5'd6;
   localparam logic [4:0] ST_BIG     = 5'd7;
   localparam logic [4:0] ST_BIGFIN  = 5'd8;
   localparam logic [4:0] ST_BIGFIN2 = 5'd9;
   localparam logic [4:0] ST_ACK     = 5'd10;
   localparam logic [4:0] ST_ACK2    = 5'd11;
   localparam logic [4:0] ST_ACKLOOP = 5'd12;
   localparam logic [4:0] ST_LK1     = 5'd13;
   localparam logic [4:0] ST_LK2     = 5'd14;
   localparam logic [4:0] ST_LK3     = 5'd15;
   localparam logic [4:0] ST_LK4     = 5'd16;
   localparam logic [4:0] ST_TREAD   = 5'd17;
   localparam logic [4:0] ST_TCMP    = 5'd18;
   localparam logic [4:0] ST_TCMP2   = 5'd19;
   localparam logic [4:0] ST_TSESS   = 5'd20;
   localparam logic [4:0] ST_OUT     = 5'd21;

   function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] x);
      return (x == LAST) ? '0 : x + 1'b1;
   endfunction

   logic [4:0]       st_ff, st_in;
   req_type          req_ff, req_in;
   logic [IW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [SEQ_W-1:0] hseq_ff, hseq_in;
   logic [MS_W-1:0]  emg_int_ff, emg_int_in;
   logic [SEQ_W-1:0] emg_seq_ff, emg_seq_in, emg_last_ff, emg_last_in;
   logic             remote_ff, remote_in;
   logic [MS_W-1:0]  ack_to_ff, ack_to_in, emg_min_ff, emg_min_in;
   logic [MS_W-1:0]  emg_max_ff, emg_max_in;
   logic [SEQ_W:0]   acc_ff, acc_in;
   logic [SEQ_W+1:0] diff_ff, diff_in;
   logic [IW-1:0]    sw_ff, sw_in;
   logic [SEQ_W-1:0] lk_ff, lk_in;
   logic             inrange_ff, inrange_in, done_ff, done_in;
   logic [CW-1:0]    back_ff, back_in;
   rsp_type          res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             we_all, we_valid;
   logic [IW-1:0]    waddr, raddr;
   slot_type         wdata, rdata;

   logic [CW-1:0]    count_w;
   logic [SEQ_W-1:0] tseq_w, dseq_w, e1_w, es_w;
   logic [MS_W-1:0]  mn_w, mx_w, ni_w;
   logic [MS_W:0]    dbl_w;

   seqrt_slot_ram #(.SLOTS(SLOTS)) u_ram (
      .clock    (clock),
      .we_all   (we_all),
      .we_valid (we_valid),
      .waddr    (waddr),
      .wdata    (wdata),
      .raddr    (raddr),
      .rdata    (rdata)
   );

   // entry count and the sequence of the oldest entry
   always_comb begin
      count_w = CW'({1'b0, head_ff} - {1'b0, tail_ff})
              + ((head_ff < tail_ff) ? SLOTS_C : '0);
      tseq_w  = hseq_ff - SEQ_W'(count_w);
   end

   // sequencer
   always_comb begin
      st_in = st_ff;         req_in = req_ff;
      head_in = head_ff;     tail_in = tail_ff;     hseq_in = hseq_ff;
      emg_int_in = emg_int_ff; emg_seq_in = emg_seq_ff; emg_last_in = emg_last_ff;
      remote_in = remote_ff;
      ack_to_in = ack_to_ff; emg_min_in = emg_min_ff; emg_max_in = emg_max_ff;
      acc_in = acc_ff;       diff_in = diff_ff;
      sw_in = sw_ff;
      lk_in = lk_ff;         inrange_in = inrange_ff; done_in = done_ff;
      back_in = back_ff;     res_in = res_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      we_all = 1'b0;         we_valid = 1'b0;
      waddr = head_ff;       raddr = tail_ff;
      wdata.valid = 1'b0;
      wdata.handle = req_ff.msg_handle;
      wdata.stamp = req_ff.now_ms;
      dseq_w = '0;           e1_w = '0;             es_w = '0;
      mn_w = (emg_min_ff == '0) ? MS_W'(1) : emg_min_ff;
      mx_w = (emg_max_ff == '0) ? MS_W'(1) : emg_max_ff;
      ni_w = emg_int_ff;
      dbl_w = {emg_int_ff, 1'b0};

      // result register drains on a taken response
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (st_ff)
         ST_CLEAR: begin
            we_valid = 1'b1;
            waddr = sw_ff;
            sw_in = inc_idx(sw_ff);
            if (sw_ff == LAST) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               st_in = ST_DEC;
            end
         end
         ST_DEC: begin
            res_in = '0;
            done_in = 1'b0;
            case (req_ff.kind)
               KIND_STORE: begin
                  acc_in = {1'b0, req_ff.seq} - {1'b0, hseq_ff};
                  st_in = ST_GAPCHK;
               end
               KIND_ACK: begin
                  remote_in = 1'b1;
                  st_in = ST_ACK;
               end
               KIND_RESEND: begin
                  remote_in = 1'b1;
                  lk_in = req_ff.seq;
                  st_in = ST_LK1;
               end
               default: begin
                  if (head_ff == tail_ff || !remote_ff) begin
                     emg_int_in = '0;
                     res_in.wait_none = 1'b1;
                     st_in = ST_OUT;
                  end else begin
                     raddr = tail_ff;
                     st_in = ST_TREAD;
                  end
               end
            endcase
         end
         // stale, no gap, small gap or large gap
         ST_GAPCHK: begin
            if (acc_ff[SEQ_W]) begin
               res_in.rejected = 1'b1;
               st_in = ST_OUT;
            end else if (acc_ff[SEQ_W-1:0] >= SLOTS_S) begin
               sw_in = '0;
               st_in = ST_BIG;
            end else if (acc_ff == '0) begin
               st_in = ST_WRITE;
            end else begin
               st_in = ST_STEP;
            end
         end
         // skip one gap sequence
         ST_STEP: begin
            we_valid = 1'b1;
            waddr = head_ff;
            head_in = inc_idx(head_ff);
            hseq_in = hseq_ff + 1'b1;
            acc_in = acc_ff - 1'b1;
            if (tail_ff == inc_idx(head_ff)) begin
               st_in = ST_FIX;
            end else if (acc_ff == (SEQ_W+1)'(1)) begin
               st_in = ST_WRITE;
            end else begin
               st_in = ST_STEP;
            end
         end
         // ring full: drop the oldest entry
         ST_FIX: begin
            we_valid = 1'b1;
            waddr = head_ff;
            tail_in = inc_idx(tail_ff);
            if (done_ff) begin
               st_in = ST_OUT;
            end else if (acc_ff == '0) begin
               st_in = ST_WRITE;
            end else begin
               st_in = ST_STEP;
            end
         end
         ST_WRITE: begin
            we_all = 1'b1;
            wdata.valid = 1'b1;
            waddr = head_ff;
            head_in = inc_idx(head_ff);
            hseq_in = hseq_ff + 1'b1;
            done_in = 1'b1;
            st_in = (tail_ff == inc_idx(head_ff)) ? ST_FIX : ST_OUT;
         end
         // clear sweep over every slot
         ST_BIG: begin
            we_valid = 1'b1;
            waddr = sw_ff;
            sw_in = inc_idx(sw_ff);
            if (sw_ff == LAST) begin
               st_in = ST_BIGFIN;
            end
         end
         // every slot is clear, so the head may stay where it is
         ST_BIGFIN: begin
            hseq_in = req_ff.seq;
            st_in = ST_BIGFIN2;
         end
         ST_BIGFIN2: begin
            tail_in = inc_idx(head_ff);
            acc_in = '0;
            st_in = ST_WRITE;
         end
         // ack: free entries from the oldest up to seq
         ST_ACK: begin
            acc_in = {1'b0, tseq_w};
            st_in = ST_ACK2;
         end
         ST_ACK2: begin
            if (hseq_ff == '0 || req_ff.seq < acc_ff[SEQ_W-1:0]) begin
               st_in = ST_OUT;
            end else begin
               if (req_ff.seq >= hseq_ff) begin
                  req_in.seq = hseq_ff - 1'b1;
               end
               st_in = ST_ACKLOOP;
            end
         end
         ST_ACKLOOP: begin
            if (acc_ff[SEQ_W-1:0] <= req_ff.seq) begin
               we_valid = 1'b1;
               waddr = tail_ff;
               tail_in = inc_idx(tail_ff);
               acc_in = acc_ff + 1'b1;
               emg_int_in = '0;
            end else begin
               st_in = ST_OUT;
            end
         end
         // lookup of lk_ff
         ST_LK1: begin
            acc_in = {1'b0, tseq_w};
            st_in = ST_LK2;
         end
         ST_LK2: begin
            inrange_in = !(lk_ff < acc_ff[SEQ_W-1:0]) && (lk_ff < hseq_ff);
            dseq_w = hseq_ff - lk_ff;
            back_in = dseq_w[CW-1:0];
            st_in = ST_LK3;
         end
         ST_LK3: begin
            if ({1'b0, head_ff} >= back_ff) begin
               raddr = IW'({1'b0, head_ff} - back_ff);
            end else begin
               raddr = IW'({1'b0, head_ff} + SLOTS_C - back_ff);
            end
            st_in = ST_LK4;
         end
         ST_LK4: begin
            if (inrange_ff && rdata.valid) begin
               res_in.do_send = 1'b1;
               res_in.send_handle = rdata.handle;
               res_in.emergency = (req_ff.kind == KIND_TICK);
            end
            st_in = ST_OUT;
         end
         // tick: deadline of the next emergency send
         ST_TREAD: begin
            if (emg_int_ff == '0) begin
               acc_in = {1'b0, (rdata.valid ? rdata.stamp : '0)}
                      + (SEQ_W+1)'(ack_to_ff);
            end else begin
               acc_in = {1'b0, emg_last_ff} + (SEQ_W+1)'(emg_int_ff);
            end
            st_in = ST_TCMP;
         end
         ST_TCMP: begin
            diff_in = {1'b0, acc_ff} - {2'b00, req_ff.now_ms};
            acc_in = {1'b0, tseq_w};
            st_in = ST_TCMP2;
         end
         ST_TCMP2: begin
            if (!diff_ff[SEQ_W+1] && diff_ff != '0) begin
               res_in.wait_ms = (diff_ff[SEQ_W+1:MS_W] != '0) ? '1 : diff_ff[MS_W-1:0];
               st_in = ST_OUT;
            end else begin
               st_in = ST_TSESS;
            end
         end
         // advance the emergency session
         ST_TSESS: begin
            e1_w = emg_seq_ff + 1'b1;
            if (emg_int_ff == '0) begin
               ni_w = mn_w;
               es_w = acc_ff[SEQ_W-1:0];
            end else if (emg_seq_ff < hseq_ff) begin
               es_w = (e1_w < acc_ff[SEQ_W-1:0]) ? acc_ff[SEQ_W-1:0] : e1_w;
            end else begin
               ni_w = (dbl_w > {1'b0, mx_w}) ? mx_w : dbl_w[MS_W-1:0];
               es_w = acc_ff[SEQ_W-1:0];
            end
            emg_int_in = ni_w;
            emg_seq_in = es_w;
            emg_last_in = req_ff.now_ms;
            res_in.wait_ms = ni_w;
            lk_in = es_w;
            st_in = ST_LK1;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in = res_ff;
               rsp_valid_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_ACK_TIMEOUT: ack_to_in = csr_wdata;
            CSR_EMG_MIN:     emg_min_in = csr_wdata;
            CSR_EMG_MAX:     emg_max_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         sw_ff        <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         hseq_ff      <= '0;
         emg_int_ff   <= '0;
         emg_seq_ff   <= '0;
         emg_last_ff  <= '0;
         remote_ff    <= 1'b0;
         ack_to_ff    <= ACK_TIMEOUT_RST;
         emg_min_ff   <= EMG_MIN_RST;
         emg_max_ff   <= EMG_MAX_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         sw_ff        <= sw_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         hseq_ff      <= hseq_in;
         emg_int_ff   <= emg_int_in;
         emg_seq_ff   <= emg_seq_in;
         emg_last_ff  <= emg_last_in;
         remote_ff    <= remote_in;
         ack_to_ff    <= ack_to_in;
         emg_min_ff   <= emg_min_in;
         emg_max_ff   <= emg_max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      acc_ff      <= acc_in;
      diff_ff     <= diff_in;
      lk_ff       <= lk_in;
      inrange_ff  <= inrange_in;
      done_ff     <= done_in;
      back_ff     <= back_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (st_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire

// ===== rtl/seqrt_checker.sv =====
// port checker for the retransmission ring, bound to the top level
`default_nettype none
`include "seq_retransmit_ring_with_backoff_core_macros.svh"
module seqrt_checker
   import seqrt_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_type         rsp_data
);
   logic stalled, send_clean, reject_clean;

   // shorthand for the response checks
   assign stalled      = rsp_valid && !rsp_ready;
   assign send_clean   = (rsp_data.send_handle == '0) && !rsp_data.emergency;
   assign reject_clean = !rsp_data.do_send && !rsp_data.wait_none && (rsp_data.wait_ms == '0);

   // a stalled response holds its payload
   `SRB_ASSERT(a_rsp_hold, clock, reset, stalled |=> rsp_valid && $stable(rsp_data), "rsp moved")

   // reset empties the output and starts the clearing sweep
   `SRB_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid && !req_ready, "busy after reset")

   // no handle or emergency flag without a send
   `SRB_ASSERT(a_no_send, clock, reset, rsp_valid && !rsp_data.do_send |-> send_clean, "stray handle")

   // a rejected store carries nothing else
   `SRB_ASSERT(a_reject, clock, reset, rsp_valid && rsp_data.rejected |-> reject_clean, "bad reject")

   // one request at a time
   `SRB_ASSERT(a_one_req, clock, reset, req_valid && req_ready |=> !req_ready, "ready after accept")
endmodule

bind seq_retransmit_ring_with_backoff_core seqrt_checker u_seqrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
